/* sv/bcg_pkg.sv */
package bcg_pkg;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_MV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PCT      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT_PCT     = 2'd3;

    localparam logic [11:0] RST_REFERENCE_MV = 12'd3300;
    localparam logic [11:0] RST_DIVIDER      = 12'd512;
    localparam logic [6:0]  RST_LOW_PCT      = 7'd20;
    localparam logic [6:0]  RST_CRIT_PCT     = 7'd10;

    // filter: millivolts with 8 fraction bits
    localparam int unsigned FV_W      = 25;
    localparam int unsigned FRAC_BITS = 8;
    localparam int unsigned MV_W      = 16;
    localparam int unsigned PCT_W     = 7;

    localparam logic [15:0] ALPHA_Q16  = 16'd6554;
    localparam logic [15:0] KEEP_Q16   = 16'd58982;  // 65536 - alpha
    localparam int unsigned ALPHA_SHIFT = 16;

    // curve: d*slope / 256000 = ((d*slope) >> 11) / 125
    localparam int unsigned D_W         = 16;
    localparam int unsigned SLOPE_W     = 8;
    localparam int unsigned PRE_SHIFT   = 11;
    localparam int unsigned Y_W         = 12;  // (d*slope) >> 11 < 2500
    localparam logic [15:0] RECIP_125   = 16'd8389;  // ceil(2^20 / 125)
    localparam int unsigned RECIP_SHIFT = 20;
    localparam int unsigned QUO_W       = 5;   // segment quotient <= 20

    localparam logic [FV_W-1:0] V_4200 = FV_W'(4200 * 256);
    localparam logic [FV_W-1:0] V_3950 = FV_W'(3950 * 256);
    localparam logic [FV_W-1:0] V_3850 = FV_W'(3850 * 256);
    localparam logic [FV_W-1:0] V_3750 = FV_W'(3750 * 256);
    localparam logic [FV_W-1:0] V_3650 = FV_W'(3650 * 256);
    localparam logic [FV_W-1:0] V_3500 = FV_W'(3500 * 256);
    localparam logic [FV_W-1:0] V_3300 = FV_W'(3300 * 256);

    typedef struct packed {
        logic [D_W-1:0]     d;         // offset into segment, 8 fraction bits
        logic [SLOPE_W-1:0] slope;     // percent per volt
        logic [PCT_W-1:0]   base_pct;  // percent at segment base
    } t_seg;

endpackage

/* sv/bcg_in_if.sv */
interface bcg_in_if #(
    parameter int ADC_BITS = 12
) ();
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

/* sv/bcg_out_if.sv */
interface bcg_out_if ();
    logic        valid;
    logic        ready;
    logic [15:0] filtered_mv;
    logic [6:0]  charge_percent;
    logic        is_low;
    logic        is_critical;

    modport source (output valid, output filtered_mv, output charge_percent,
                    output is_low, output is_critical, input ready);
    modport sink   (input valid, input filtered_mv, input charge_percent,
                    input is_low, input is_critical, output ready);
endinterface

/* sv/battery_charge_gauge_core.sv */
// Channel  | Dir | Handshake          | Word
// ---------+-----+--------------------+------------------------------------------------
// i_smp    | in  | valid/ready        | adc_sample[ADC_BITS]
// o_res    | out | valid/ready        | filtered_mv[16], charge_percent[7], is_low,
//          |     |                    | is_critical
// i_cfg_*  | in  | write enable only  | i_cfg_idx[2], i_cfg_data[12]
//
// From acceptance to o_res.valid a word passes the reference and divider
// products, the fold step of the divide by 2^ADC_BITS-1 (folding passes, then
// the exit check), the filter (skipped for the first word after reset) and the
// curve lookup. The single multiplier/accumulator is the bottleneck:
// every product goes through it.
// Reset (synchronous, active low) empties the filter and restores the register
// defaults. A result waits in the output register; the sequencer holds in its
// last step until that register is free, and i_smp.ready is high only when idle.
module battery_charge_gauge_core
    import bcg_pkg::*;
#(
    parameter int ADC_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bcg_in_if.sink                i_smp,
    bcg_out_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // multiplier operand widths: raw*ref needs ADC_BITS+12, the filter needs 25
    localparam int MA_W  = (ADC_BITS + 12 > FV_W) ? ADC_BITS + 12 : FV_W;
    localparam int MB_W  = 16;
    localparam int PR_W  = MA_W + MB_W;
    localparam int ACC_W = PR_W + 1;
    localparam int P_W   = ADC_BITS + 24;   // raw * ref * divider
    localparam int HI_W  = P_W - ADC_BITS;

    // sequencer
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL1  = 4'd1;  // raw * reference
    localparam logic [3:0] S_MUL2  = 4'd2;  // * divider
    localparam logic [3:0] S_FOLD  = 4'd3;  // divide by 2^N-1, one fold per cycle
    localparam logic [3:0] S_FLT1  = 4'd4;  // f * (1 - alpha)
    localparam logic [3:0] S_FLT2  = 4'd5;  // + x * alpha, >> 16
    localparam logic [3:0] S_SEG   = 4'd6;  // curve segment lookup
    localparam logic [3:0] S_SLOPE = 4'd7;  // d * slope
    localparam logic [3:0] S_RECIP = 4'd8;  // (>> 11) * 1/125
    localparam logic [3:0] S_DONE  = 4'd9;  // percent, flags, output load

    logic [3:0] r_state, n_state;

    // configuration registers
    logic [11:0]      r_ref_mv;
    logic [11:0]      r_div;
    logic [PCT_W-1:0] r_low;
    logic [PCT_W-1:0] r_crit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_mv <= RST_REFERENCE_MV;
            r_div    <= RST_DIVIDER;
            r_low    <= RST_LOW_PCT;
            r_crit   <= RST_CRIT_PCT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REFERENCE_MV: r_ref_mv <= i_cfg_data;
                CFG_DIVIDER:      r_div    <= i_cfg_data;
                CFG_LOW_PCT:      r_low    <= i_cfg_data[PCT_W-1:0];
                CFG_CRIT_PCT:     r_crit   <= i_cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // datapath registers
    logic [ADC_BITS-1:0] r_raw;
    logic [ACC_W-1:0]    r_acc;
    logic [P_W-1:0]      r_p;     // running fold value
    logic [FV_W-1:0]     r_q;     // running quotient
    logic [FV_W-1:0]     r_x;     // scaled sample
    logic [FV_W-1:0]     r_fv;    // filter state
    logic                r_primed;
    t_seg                r_seg;

    // shared multiplier
    logic [MA_W-1:0] mul_a;
    logic [MB_W-1:0] mul_b;
    logic [PR_W-1:0] prod;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL1: begin
                mul_a = MA_W'(r_raw);
                mul_b = MB_W'(r_ref_mv);
            end
            S_MUL2: begin
                mul_a = MA_W'(r_acc[ADC_BITS+11:0]);
                mul_b = MB_W'(r_div);
            end
            S_FLT1: begin
                mul_a = MA_W'(r_fv);
                mul_b = KEEP_Q16;
            end
            S_FLT2: begin
                mul_a = MA_W'(r_x);
                mul_b = ALPHA_Q16;
            end
            S_SLOPE: begin
                mul_a = MA_W'(r_seg.d);
                mul_b = MB_W'(r_seg.slope);
            end
            S_RECIP: begin
                mul_a = MA_W'(r_acc[PRE_SHIFT +: Y_W]);
                mul_b = RECIP_125;
            end
            default: ;
        endcase
    end

    assign prod = PR_W'(mul_a) * PR_W'(mul_b);

    // fold: p = hi*2^N + lo = hi*(2^N-1) + (hi + lo)
    logic [HI_W-1:0]     fold_hi;
    logic [ADC_BITS-1:0] fold_lo;
    logic [P_W-1:0]      fold_sum;
    logic [FV_W-1:0]     x_val;

    assign fold_hi  = r_p[P_W-1:ADC_BITS];
    assign fold_lo  = r_p[ADC_BITS-1:0];
    assign fold_sum = P_W'(fold_hi) + P_W'(fold_lo);
    // remainder of exactly 2^N-1 is one more unit of quotient
    assign x_val    = r_q + FV_W'(fold_lo == {ADC_BITS{1'b1}});

    logic [ACC_W-1:0] flt_sum;
    assign flt_sum = r_acc + ACC_W'(prod);

    t_seg seg;
    bcg_seg u_seg (
        .i_fv  (r_fv),
        .o_seg (seg)
    );

    // final percent and flags
    logic [PCT_W-1:0] pct;
    assign pct = r_seg.base_pct + PCT_W'(r_acc[RECIP_SHIFT +: QUO_W]);

    logic r_ovld;
    logic out_free;
    logic out_load;
    assign out_free = !r_ovld || o_res.ready;
    assign out_load = (r_state == S_DONE) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_smp.valid) n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_FOLD;
            S_FOLD:  begin
                if (fold_hi == '0) n_state = r_primed ? S_FLT1 : S_SEG;
            end
            S_FLT1:  n_state = S_FLT2;
            S_FLT2:  n_state = S_SEG;
            S_SEG:   n_state = S_SLOPE;
            S_SLOPE: n_state = S_RECIP;
            S_RECIP: n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_primed <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FOLD && fold_hi == '0) r_primed <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: r_raw <= i_smp.adc_sample;
            S_MUL1: r_acc <= ACC_W'(prod);
            S_MUL2: begin
                r_p <= prod[P_W-1:0];
                r_q <= '0;
            end
            S_FOLD: begin
                if (fold_hi != '0) begin
                    r_p <= fold_sum;
                    r_q <= r_q + FV_W'(fold_hi);
                end else begin
                    r_x <= x_val;
                    if (!r_primed) r_fv <= x_val;   // first sample loads the filter
                end
            end
            S_FLT1:  r_acc <= ACC_W'(prod);
            S_FLT2:  r_fv  <= flt_sum[ALPHA_SHIFT +: FV_W];
            S_SEG:   r_seg <= seg;
            S_SLOPE: r_acc <= ACC_W'(prod);
            S_RECIP: r_acc <= ACC_W'(prod);
            default: ;
        endcase
    end

    // output register
    logic [MV_W-1:0]  r_o_mv;
    logic [PCT_W-1:0] r_o_pct;
    logic             r_o_low;
    logic             r_o_crit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (out_load) begin
            r_ovld <= 1'b1;
        end else if (o_res.ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_mv   <= r_fv[FRAC_BITS +: MV_W];
            r_o_pct  <= pct;
            r_o_low  <= (pct <= r_low);
            r_o_crit <= (pct <= r_crit);
        end
    end

    assign i_smp.ready          = (r_state == S_IDLE);
    assign o_res.valid          = r_ovld;
    assign o_res.filtered_mv    = r_o_mv;
    assign o_res.charge_percent = r_o_pct;
    assign o_res.is_low         = r_o_low;
    assign o_res.is_critical    = r_o_crit;

endmodule

/* sv/bcg_seg.sv */
module bcg_seg
    import bcg_pkg::*;
(
    input  logic [FV_W-1:0] i_fv,
    output t_seg            o_seg
);

    logic [FV_W-1:0] base;

    always_comb begin
        base           = '0;
        o_seg.slope    = '0;
        o_seg.base_pct = '0;
        priority if (i_fv >= V_4200) begin
            base           = i_fv;   // flat top, d = 0
            o_seg.base_pct = 7'd100;
        end else if (i_fv >= V_3950) begin
            base = V_3950; o_seg.slope = 8'd80;  o_seg.base_pct = 7'd80;
        end else if (i_fv >= V_3850) begin
            base = V_3850; o_seg.slope = 8'd200; o_seg.base_pct = 7'd60;
        end else if (i_fv >= V_3750) begin
            base = V_3750; o_seg.slope = 8'd200; o_seg.base_pct = 7'd40;
        end else if (i_fv >= V_3650) begin
            base = V_3650; o_seg.slope = 8'd200; o_seg.base_pct = 7'd20;
        end else if (i_fv >= V_3500) begin
            base = V_3500; o_seg.slope = 8'd100; o_seg.base_pct = 7'd10;
        end else if (i_fv >= V_3300) begin
            base = V_3300; o_seg.slope = 8'd33;  o_seg.base_pct = 7'd0;
        end else begin
            base = i_fv;   // empty, d = 0
        end
        // widest segment is 250 mV < 2^16 / 256
        o_seg.d = D_W'(i_fv - base);
    end

endmodule

/* sv/bcg_checker.sv */
module bcg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_filtered_mv,
    input logic [6:0]  i_charge_percent,
    input logic        i_is_low,
    input logic        i_is_critical
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_filtered_mv)
            && $stable(i_charge_percent) && $stable(i_is_low) && $stable(i_is_critical))
        else $error("output word changed while stalled");

    // one word at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while busy");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_charge_percent <= 7'd100)
        else $error("percent above 100");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_filtered_mv >= 16'd4200 |-> i_charge_percent == 7'd100)
        else $error("full cell not at 100 percent");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_filtered_mv < 16'd3300 |-> i_charge_percent == 7'd0)
        else $error("empty cell not at 0 percent");

endmodule

bind battery_charge_gauge_core bcg_checker u_bcg_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_smp.valid),
    .i_in_ready       (i_smp.ready),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_filtered_mv    (o_res.filtered_mv),
    .i_charge_percent (o_res.charge_percent),
    .i_is_low         (o_res.is_low),
    .i_is_critical    (o_res.is_critical)
);

/* sim/tb_battery_charge_gauge_core.sv */
`timescale 1ns / 1ps

module tb_battery_charge_gauge_core;
    import bcg_pkg::*;

    localparam int ADC_BITS   = 12;
    localparam int ADC_MAX    = (1 << ADC_BITS) - 1;
    localparam int CLK_HALF   = 5;
    // drain pause: worst case sequencer run for one word, plus margin
    localparam int TAIL_CYCLES = 24;

    // one result word as the gauge presents it
    typedef struct packed {
        logic [MV_W-1:0]  mv;
        logic [PCT_W-1:0] pct;
        logic             low;
        logic             crit;
    } t_gauge_word;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the register file and the filter state, works
    // out the expected word for each accepted sample and queues it until
    // the gauge hands the matching word out.
    // ------------------------------------------------------------------
    class gauge_scoreboard;
        logic [11:0]      ref_mv;
        logic [11:0]      div_q88;
        logic [PCT_W-1:0] low_pct;
        logic [PCT_W-1:0] crit_pct;
        logic [FV_W-1:0]  filt_mv8;
        bit               primed;
        t_gauge_word      pending[$];
        int               n_samples;
        int               n_checked;
        int               n_errors;

        function new();
            ref_mv    = RST_REFERENCE_MV;
            div_q88   = RST_DIVIDER;
            low_pct   = RST_LOW_PCT;
            crit_pct  = RST_CRIT_PCT;
            filt_mv8  = '0;
            primed    = 1'b0;
            n_samples = 0;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        // register write: only the register's own width is kept
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_REFERENCE_MV: ref_mv   = data[11:0];
                CFG_DIVIDER:      div_q88  = data[11:0];
                CFG_LOW_PCT:      low_pct  = data[PCT_W-1:0];
                CFG_CRIT_PCT:     crit_pct = data[PCT_W-1:0];
                default: ;
            endcase
        endfunction

        // piecewise LiPo curve on millivolts with 8 fraction bits, truncated
        function logic [PCT_W-1:0] charge_from_mv8(logic [FV_W-1:0] v8);
            longint unsigned v;
            longint unsigned k;
            longint unsigned p;
            v = v8;
            k = 1000 * 256;
            if (v >= 4200 * 256)      p = 100;
            else if (v >= 3950 * 256) p = 80 + ((v - 3950 * 256) * 80) / k;
            else if (v >= 3850 * 256) p = 60 + ((v - 3850 * 256) * 200) / k;
            else if (v >= 3750 * 256) p = 40 + ((v - 3750 * 256) * 200) / k;
            else if (v >= 3650 * 256) p = 20 + ((v - 3650 * 256) * 200) / k;
            else if (v >= 3500 * 256) p = 10 + ((v - 3500 * 256) * 100) / k;
            else if (v >= 3300 * 256) p = ((v - 3300 * 256) * 33) / k;
            else                      p = 0;
            return PCT_W'(p);
        endfunction

        function void note_sample(logic [ADC_BITS-1:0] raw);
            longint unsigned x;
            longint unsigned f;
            t_gauge_word     w;
            x = (longint'(raw) * longint'(ref_mv) * longint'(div_q88)) / ADC_MAX;
            x = x & 64'h1FF_FFFF;
            if (!primed) begin
                f      = x;
                primed = 1'b1;
            end else begin
                f = (longint'(filt_mv8) * longint'(KEEP_Q16) + x * longint'(ALPHA_Q16))
                    >> ALPHA_SHIFT;
            end
            filt_mv8 = FV_W'(f);
            w.mv     = MV_W'(filt_mv8 >> FRAC_BITS);
            w.pct    = charge_from_mv8(filt_mv8);
            w.low    = (w.pct <= low_pct);
            w.crit   = (w.pct <= crit_pct);
            pending.push_back(w);
            n_samples++;
        endfunction

        function void check_result(t_gauge_word got);
            t_gauge_word want;
            if (pending.size() == 0) begin
                $error("result word with nothing pending: mv=%0d pct=%0d", got.mv, got.pct);
                n_errors++;
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (got.mv !== want.mv) begin
                $error("filtered_mv: expected %0d, got %0d", want.mv, got.mv);
                n_errors++;
            end
            if (got.pct !== want.pct) begin
                $error("charge_percent: expected %0d, got %0d", want.pct, got.pct);
                n_errors++;
            end
            if (got.low !== want.low) begin
                $error("is_low: expected %0b, got %0b", want.low, got.low);
                n_errors++;
            end
            if (got.crit !== want.crit) begin
                $error("is_critical: expected %0b, got %0b", want.crit, got.crit);
                n_errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  rcv_ready = 1'b0;

    int snd_idle_pct = 0;   // chance per word that the sender holds off
    int rcv_idle_pct = 0;   // chance per cycle that the receiver stalls
    int n_settings   = 0;

    gauge_scoreboard sb = new();

    bcg_in_if #(.ADC_BITS(ADC_BITS)) smp_if ();
    bcg_out_if                        res_if ();

    assign res_if.ready = rcv_ready;

    always #CLK_HALF i_clk = ~i_clk;

    battery_charge_gauge_core #(
        .ADC_BITS(ADC_BITS)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_smp     (smp_if),
        .o_res     (res_if),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    // Receiver back-pressure. Held low through reset.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rcv_ready <= 1'b0;
        end else begin
            rcv_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Result monitor: values sampled here are the ones present at the edge,
    // since every testbench driver updates through nonblocking assignments.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && rcv_ready) begin
            sb.check_result('{res_if.filtered_mv, res_if.charge_percent,
                              res_if.is_low, res_if.is_critical});
        end
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #5_000_000;
        $display("FAIL battery_charge_gauge_core");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one sample word and hold it until accepted. valid is left high
    // on return so back-to-back words keep it up without a glitch.
    task automatic send_sample(input logic [ADC_BITS-1:0] raw);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            smp_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_if.valid      <= 1'b1;
        smp_if.adc_sample <= raw;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        sb.note_sample(raw);
    endtask

    // Drop valid, wait for every pending word, then let the pipe settle so
    // that register writes land on an idle block.
    task automatic drain_gauge();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers on consecutive cycles. Threshold data may carry
    // junk above bit 6 to exercise width truncation.
    task automatic apply_settings(input logic [11:0] ref_v, input logic [11:0] div_v,
                                  input logic [11:0] low_v, input logic [11:0] crit_v);
        logic [CFG_DATA_W-1:0] vals[4];
        vals[0] = ref_v;
        vals[1] = div_v;
        vals[2] = low_v;
        vals[3] = crit_v;
        for (int i = 0; i < 4; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_W'(i);
            cfg_data <= vals[i];
            @(posedge i_clk);
            sb.set_reg(CFG_IDX_W'(i), vals[i]);
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
        n_settings++;
    endtask

    // Random traffic. Mostly steady battery levels with ADC jitter, held long
    // enough for the slow filter to settle into each curve segment; the rest
    // is uniform noise across the full code range.
    task automatic run_traffic(input int n_items);
        int              left;
        int              level;
        int              s;
        int              mv;
        longint unsigned scale;
        left  = 0;
        level = 0;
        for (int i = 0; i < n_items; i++) begin
            if (left == 0) begin
                left  = $urandom_range(10, 40);
                scale = longint'(sb.ref_mv) * longint'(sb.div_q88);
                mv    = $urandom_range(3200, 4300);
                if (scale == 0 || $urandom_range(0, 5) == 0) begin
                    level = $urandom_range(0, ADC_MAX);
                end else begin
                    level = int'((longint'(mv) * 256 * ADC_MAX) / scale);
                    if (level > ADC_MAX) level = ADC_MAX;
                end
            end
            left--;
            if ($urandom_range(0, 4) == 0) begin
                s = $urandom_range(0, ADC_MAX);
            end else begin
                s = level + $urandom_range(0, 16) - 8;
                if (s < 0) s = 0;
                if (s > ADC_MAX) s = ADC_MAX;
            end
            send_sample(ADC_BITS'(s));
        end
    endtask

    task automatic random_settings_phase(input int n_items);
        apply_settings(12'($urandom_range(1000, 4095)), 12'($urandom_range(256, 1536)),
                       12'($urandom), 12'($urandom));
        run_traffic(n_items);
        drain_gauge();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    int directed[$] = '{2500, 0, 4095, 4095, 1, 2048, 2730, 2730, 2606, 2606,
                        2451, 2389, 2327, 2265, 2172, 2048, 2047, 12'hAAA, 12'h555, 3000};

    initial begin
        i_rst_n           <= 1'b0;
        smp_if.valid      <= 1'b0;
        smp_if.adc_sample <= '0;
        cfg_we            <= 1'b0;
        cfg_idx           <= '0;
        cfg_data          <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- sender mostly busy, receiver stalling more than half the time
        snd_idle_pct = 12;
        rcv_idle_pct = 58;

        // Directed words on reset defaults: the first one loads the filter
        // directly, then code extremes and points around each curve knee.
        foreach (directed[i]) send_sample(ADC_BITS'(directed[i]));
        drain_gauge();

        apply_settings(12'd3300, 12'd512, 12'd20, 12'd10);
        run_traffic(150);
        drain_gauge();

        // full-scale reference and divider, thresholds at the range ends
        apply_settings(12'd4095, 12'd4095, 12'd100, 12'd0);
        run_traffic(110);
        drain_gauge();

        // everything zero: the filtered voltage decays to zero; both flags set once percent is 0
        apply_settings(12'd0, 12'd0, 12'd0, 12'd0);
        run_traffic(40);
        drain_gauge();

        // --- swap the idle pattern
        snd_idle_pct = 58;
        rcv_idle_pct = 12;

        // thresholds above 100 (junk in the upper data bits): flags always on
        apply_settings(12'd2500, 12'd700, 12'hF7F, 12'h065);
        run_traffic(110);
        drain_gauge();

        apply_settings(12'd1800, 12'd1024, 12'd50, 12'd25);
        run_traffic(110);
        drain_gauge();

        random_settings_phase(110);

        // --- no idling at all
        snd_idle_pct = 0;
        rcv_idle_pct = 0;

        random_settings_phase(110);

        // smallest non-zero divider, then smallest reference
        apply_settings(12'd4095, 12'd1, 12'd127, 12'd100);
        run_traffic(30);
        drain_gauge();
        apply_settings(12'd1, 12'd4095, 12'd0, 12'd127);
        run_traffic(30);
        drain_gauge();

        // back to defaults with junk above the threshold bits
        apply_settings(12'd3300, 12'd512, 12'hA14, 12'h50A);
        run_traffic(180);
        drain_gauge();

        // anything still queued here is a lost word
        if (sb.pending.size() != 0) begin
            $error("%0d result words never arrived", sb.pending.size());
            sb.n_errors += sb.pending.size();
        end

        $display("Gauge run: %0d samples sent, %0d results checked, %0d register settings",
                 sb.n_samples, sb.n_checked, n_settings);
        $display("Covered curve segments, register extremes and three back-pressure mixes");
        if (sb.n_errors == 0) begin
            $display("PASS battery_charge_gauge_core");
        end else begin
            $display("FAIL battery_charge_gauge_core");
        end
        $finish;
    end

endmodule

/* battery_charge_gauge_core.f */
sv/bcg_pkg.sv
sv/bcg_in_if.sv
sv/bcg_out_if.sv
sv/bcg_seg.sv
sv/battery_charge_gauge_core.sv
sv/bcg_checker.sv
sim/tb_battery_charge_gauge_core.sv
